// ----- rtl/i2cscp_pkg.sv -----
// i2cscp_pkg: shared types and constants of the command packet port
// no dependencies; imported by every module
`default_nettype none

package i2cscp_pkg;

  localparam int RECV_DEPTH_DEF = 16;
  localparam int REPLY_BYTES    = 6;
  localparam logic [7:0] BYTE_ONES = 8'hff;

  localparam logic [2:0] CMD_ADDR_MATCH = 3'd0;
  localparam logic [2:0] CMD_TX_REQ     = 3'd1;
  localparam logic [2:0] CMD_TX_NAK     = 3'd2;
  localparam logic [2:0] CMD_RX_BYTE    = 3'd3;
  localparam logic [2:0] CMD_STOP       = 3'd4;
  localparam logic [2:0] CMD_LOAD_WORD  = 3'd5;
  localparam logic [2:0] CMD_DONE       = 3'd6;
  localparam logic [2:0] CMD_READ       = 3'd7;

  localparam logic [1:0] SLOT_COUNT = 2'd3;

  typedef struct packed {
    logic [2:0]  command;
    logic [7:0]  rx_byte;
    logic [1:0]  word_slot;
    logic [15:0] word_value;
    logic [3:0]  read_index;
  } item_t;

  typedef struct packed {
    logic       halt_set;
    logic       dropped;
    logic       ready;
    logic [7:0] count;
    logic [7:0] read_data;
  } recv_stat_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_valid;
  } reply_stat_t;

endpackage

`default_nettype wire

// ----- rtl/i2cscp_if.sv -----
// i2cscp_cmd_if / i2cscp_res_if: valid-ready channels for event and result beats
// no dependencies
`default_nettype none

interface i2cscp_cmd_if;
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [7:0]  rx_byte;
  logic [1:0]  word_slot;
  logic [15:0] word_value;
  logic [3:0]  read_index;

  modport source (output valid, command, rx_byte, word_slot, word_value, read_index,
                  input ready);
  modport sink (input valid, command, rx_byte, word_slot, word_value, read_index,
                output ready);
endinterface

interface i2cscp_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] tx_byte;
  logic       tx_valid;
  logic       power_off;
  logic       ready_res;
  logic [7:0] recv_count;
  logic [7:0] read_data;
  logic       rx_dropped;

  modport source (output valid, tx_byte, tx_valid, power_off, ready_res, recv_count,
                  read_data, rx_dropped, input ready);
  modport sink (input valid, tx_byte, tx_valid, power_off, ready_res, recv_count,
                read_data, rx_dropped, output ready);
endinterface

`default_nettype wire

// ----- rtl/i2cscp_recv.sv -----
// i2cscp_recv: receive packet state, length tracking and receive store memory
// depends on i2cscp_pkg
`default_nettype none

module i2cscp_recv
  import i2cscp_pkg::*;
#(
  parameter int RECV_DEPTH = RECV_DEPTH_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       acc,
  input  wire logic [3:0] acc_index,
  input  wire logic       go,
  input  wire item_t      item,
  output recv_stat_t      stat
);

  localparam int ADDR_W = $clog2(RECV_DEPTH);
  localparam int POS_W  = $clog2(RECV_DEPTH + 1);
  localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(RECV_DEPTH);
  localparam logic [7:0] DEPTH_B = 8'(RECV_DEPTH);

  logic [7:0] mem [RECV_DEPTH];

  logic [POS_W-1:0] recv_pos_r, recv_pos_nxt;
  logic [7:0]       packet_len_r, packet_len_nxt;
  logic             got_len_r, got_len_nxt;
  logic             ready_r, ready_nxt;
  logic [7:0]       rd_r;

  logic              we;
  logic              halt_set;
  logic              dropped;
  logic [ADDR_W-1:0] waddr;
  logic [ADDR_W-1:0] raddr;
  logic [7:0]        acc_idx_b;
  logic              acc_in_range;
  logic              item_in_range;
  logic [8:0]        pos_p1;
  logic              room;

  assign waddr  = recv_pos_r[ADDR_W-1:0];
  assign pos_p1 = 9'(recv_pos_r) + 9'd1;
  assign room   = (recv_pos_r < POS_LIMIT) && (pos_p1 < {1'b0, packet_len_r});

  always_comb begin
    recv_pos_nxt   = recv_pos_r;
    packet_len_nxt = packet_len_r;
    got_len_nxt    = got_len_r;
    ready_nxt      = ready_r;
    we             = 1'b0;
    halt_set       = 1'b0;
    dropped        = 1'b0;
    if (go) begin
      case (item.command)
        CMD_ADDR_MATCH: begin
          recv_pos_nxt = '0;
          got_len_nxt  = 1'b0;
        end
        CMD_RX_BYTE: begin
          if (!got_len_r) begin
            packet_len_nxt = item.rx_byte;
            if (item.rx_byte == 8'd0) begin
              halt_set = 1'b1;
            end else begin
              got_len_nxt = 1'b1;
            end
          end else if (room) begin
            we           = 1'b1;
            recv_pos_nxt = recv_pos_r + POS_W'(1);
          end else begin
            dropped = 1'b1;
          end
        end
        CMD_STOP: ready_nxt = 1'b1;
        CMD_DONE: ready_nxt = 1'b0;
        default: ;
      endcase
    end
  end

  // read at accept, forwarding a write that lands on the same edge
  assign acc_idx_b    = {4'd0, acc_index};
  assign acc_in_range = acc_idx_b < DEPTH_B;
  assign raddr        = acc_idx_b[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= item.rx_byte;
    end
    if (acc) begin
      if (we && (waddr == raddr)) begin
        rd_r <= item.rx_byte;
      end else if (acc_in_range) begin
        rd_r <= mem[raddr];
      end else begin
        rd_r <= 8'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      recv_pos_r   <= '0;
      packet_len_r <= 8'd0;
      got_len_r    <= 1'b0;
      ready_r      <= 1'b0;
    end else begin
      recv_pos_r   <= recv_pos_nxt;
      packet_len_r <= packet_len_nxt;
      got_len_r    <= got_len_nxt;
      ready_r      <= ready_nxt;
    end
  end

  assign item_in_range  = {4'd0, item.read_index} < DEPTH_B;
  assign stat.halt_set  = halt_set;
  assign stat.dropped   = dropped;
  assign stat.ready     = ready_nxt;
  assign stat.count     = ready_nxt ? ((packet_len_nxt - 8'd1) & BYTE_ONES) : 8'd0;
  assign stat.read_data = (item.command == CMD_READ && item_in_range) ? rd_r : 8'd0;

endmodule

`default_nettype wire

// ----- rtl/i2cscp_reply.sv -----
// i2cscp_reply: staged reply words, transmit snapshot and send position
// depends on i2cscp_pkg
`default_nettype none

module i2cscp_reply
  import i2cscp_pkg::*;
(
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  go,
  input  wire item_t item,
  output reply_stat_t stat
);

  localparam logic [2:0] SEND_END = 3'(REPLY_BYTES);

  logic [7:0] staged_r [REPLY_BYTES];
  logic [7:0] snap_r   [REPLY_BYTES];
  logic [2:0] send_pos_r, send_pos_nxt;

  logic       is_tx;
  logic       take_snap;
  logic       load_ok;
  logic [2:0] lo_idx;
  logic [2:0] hi_idx;

  assign is_tx     = (item.command == CMD_TX_REQ) || (item.command == CMD_TX_NAK);
  assign take_snap = go && is_tx && (send_pos_r == 3'd0);
  assign load_ok   = go && (item.command == CMD_LOAD_WORD) && (item.word_slot < SLOT_COUNT);
  assign hi_idx    = {item.word_slot, 1'b0};
  assign lo_idx    = {item.word_slot, 1'b1};

  always_comb begin
    send_pos_nxt  = send_pos_r;
    stat.tx_valid = 1'b0;
    stat.tx_byte  = 8'd0;
    if (item.command == CMD_TX_REQ) begin
      stat.tx_valid = 1'b1;
      if (send_pos_r == 3'd0) begin
        stat.tx_byte = staged_r[0];
      end else if (send_pos_r < SEND_END) begin
        stat.tx_byte = snap_r[send_pos_r];
      end
    end
    if (go) begin
      case (item.command)
        CMD_ADDR_MATCH: send_pos_nxt = 3'd0;
        CMD_TX_REQ: begin
          if (send_pos_r < SEND_END) begin
            send_pos_nxt = send_pos_r + 3'd1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      send_pos_r <= 3'd0;
      for (int i = 0; i < REPLY_BYTES; i++) begin
        staged_r[i] <= 8'd0;
        snap_r[i]   <= 8'd0;
      end
    end else begin
      send_pos_r <= send_pos_nxt;
      if (take_snap) begin
        for (int i = 0; i < REPLY_BYTES; i++) begin
          snap_r[i] <= staged_r[i];
        end
      end
      if (load_ok) begin
        staged_r[hi_idx] <= item.word_value[15:8];
        staged_r[lo_idx] <= item.word_value[7:0];
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/i2c_slave_command_packet_port_core.sv -----
// i2c_slave_command_packet_port_core: top level of the command packet port
// depends on i2cscp_pkg, i2cscp_if, i2cscp_recv, i2cscp_reply
//
//  channel  | dir | beat contents
//  in_if    | in  | command, rx_byte, word_slot, word_value, read_index
//  out_if   | out | tx_byte, tx_valid, power_off, ready_res, recv_count, read_data, rx_dropped
//
// one beat per cycle sustained while out_if is not stalled; each beat passes the input register,
// then the state update and result register
// the receive store is read on the accept edge, with a bypass for a same-edge write
// a stall on out_if holds the result register and the input register; in_if.ready
// stays high while the input register is free
// rst_n clears control state, reply bytes and the power-off latch; the store is not cleared
`default_nettype none

module i2c_slave_command_packet_port_core
  import i2cscp_pkg::*;
#(
  parameter int RECV_DEPTH = RECV_DEPTH_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  i2cscp_cmd_if.sink    in_if,
  i2cscp_res_if.source  out_if
);

  logic        s1_v_r;
  item_t       s1_item_r;
  logic        out_v_r;
  logic [7:0]  tx_byte_r;
  logic        tx_valid_r;
  logic        power_off_r;
  logic        ready_res_r;
  logic [7:0]  recv_count_r;
  logic [7:0]  read_data_r;
  logic        rx_dropped_r;
  logic        halted_r, halted_nxt;

  logic        adv;
  logic        acc;
  logic        go;
  item_t       in_item;
  recv_stat_t  rstat;
  reply_stat_t tstat;

  assign adv         = s1_v_r && (!out_v_r || out_if.ready);
  assign in_if.ready = !s1_v_r || adv;
  assign acc         = in_if.valid && in_if.ready;
  assign go          = adv && !halted_r;
  assign halted_nxt  = halted_r || (go && rstat.halt_set);

  assign in_item.command    = in_if.command;
  assign in_item.rx_byte    = in_if.rx_byte;
  assign in_item.word_slot  = in_if.word_slot;
  assign in_item.word_value = in_if.word_value;
  assign in_item.read_index = in_if.read_index;

  i2cscp_recv #(
    .RECV_DEPTH(RECV_DEPTH)
  ) u_recv (
    .clk      (clk),
    .rst_n    (rst_n),
    .acc      (acc),
    .acc_index(in_if.read_index),
    .go       (go),
    .item     (s1_item_r),
    .stat     (rstat)
  );

  i2cscp_reply u_reply (
    .clk  (clk),
    .rst_n(rst_n),
    .go   (go),
    .item (s1_item_r),
    .stat (tstat)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r   <= 1'b0;
      out_v_r  <= 1'b0;
      halted_r <= 1'b0;
    end else begin
      halted_r <= halted_nxt;
      if (acc) begin
        s1_v_r <= 1'b1;
      end else if (adv) begin
        s1_v_r <= 1'b0;
      end
      if (adv) begin
        out_v_r <= 1'b1;
      end else if (out_if.ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_item_r <= in_item;
    end
    if (adv) begin
      if (halted_nxt) begin
        tx_byte_r    <= 8'd0;
        tx_valid_r   <= 1'b0;
        power_off_r  <= 1'b1;
        ready_res_r  <= 1'b0;
        recv_count_r <= 8'd0;
        read_data_r  <= 8'd0;
        rx_dropped_r <= 1'b0;
      end else begin
        tx_byte_r    <= tstat.tx_byte;
        tx_valid_r   <= tstat.tx_valid;
        power_off_r  <= 1'b0;
        ready_res_r  <= rstat.ready;
        recv_count_r <= rstat.count;
        read_data_r  <= rstat.read_data;
        rx_dropped_r <= rstat.dropped;
      end
    end
  end

  assign out_if.valid      = out_v_r;
  assign out_if.tx_byte    = tx_byte_r;
  assign out_if.tx_valid   = tx_valid_r;
  assign out_if.power_off  = power_off_r;
  assign out_if.ready_res  = ready_res_r;
  assign out_if.recv_count = recv_count_r;
  assign out_if.read_data  = read_data_r;
  assign out_if.rx_dropped = rx_dropped_r;

endmodule

`default_nettype wire
